// ----- hw/rtl/wegc_pkg.sv -----
`default_nettype none
package wegc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int WHEELS = 4;
	localparam int FIELD_W = 32;
	localparam int CNT_W = COUNT_WIDTH;
	localparam int DELTA_W = COUNT_WIDTH + 1;
	localparam int SUM_W = COUNT_WIDTH + 3;
	localparam int CMP_W = (SUM_W > FIELD_W) ? SUM_W : FIELD_W;
	localparam int THR_W = 31;
	localparam int RUN_W = 4;
	localparam int PADDR_W = 3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_READ_FAIL = 2'd2;

	localparam logic REG_ERROR_THRESHOLD = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	typedef struct packed {
		logic ge;
		logic le;
		logic over;
	} lane_flags_t;

	typedef struct packed {
		logic [1:0] status;
		logic       retry;
		logic       reset;
		logic       rollback;
	} decision_t;

	typedef struct packed {
		logic [1:0]                        status;
		logic                              retry;
		logic                              reset;
		logic [WHEELS-1:0][FIELD_W-1:0]    kept;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/wegc_sample_if.sv -----
`default_nettype none
interface wegc_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] count_front_left;
	logic signed [31:0] count_front_right;
	logic signed [31:0] count_back_left;
	logic signed [31:0] count_back_right;

	modport source (
		output valid, count_front_left, count_front_right, count_back_left, count_back_right,
		input  ready
	);
	modport sink (
		input  valid, count_front_left, count_front_right, count_back_left, count_back_right,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/wegc_result_if.sv -----
`default_nettype none
interface wegc_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         check_status;
	logic               retry_wanted;
	logic               reset_request;
	logic signed [31:0] kept_front_left;
	logic signed [31:0] kept_front_right;
	logic signed [31:0] kept_back_left;
	logic signed [31:0] kept_back_right;

	modport source (
		output valid, check_status, retry_wanted, reset_request,
		output kept_front_left, kept_front_right, kept_back_left, kept_back_right,
		input  ready
	);
	modport sink (
		input  valid, check_status, retry_wanted, reset_request,
		input  kept_front_left, kept_front_right, kept_back_left, kept_back_right,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/wegc_lane.sv -----
`default_nettype none
module wegc_lane
	import wegc_pkg::*;
(
	input  logic [CNT_W-1:0]          smp,
	input  logic [CNT_W-1:0]          cur,
	input  logic signed [DELTA_W-1:0] mean,
	input  logic [THR_W-1:0]          thr,
	output logic signed [DELTA_W-1:0] delta,
	output lane_flags_t               flags
);

	logic signed [SUM_W-1:0] dev;
	logic [SUM_W-1:0]        mag;

	always_comb begin
		delta = DELTA_W'($signed(smp)) - DELTA_W'($signed(cur));
		dev = SUM_W'(delta) - SUM_W'(mean);
		mag = dev[SUM_W-1] ? SUM_W'(-dev) : SUM_W'(dev);
		flags.ge = !delta[DELTA_W-1];
		flags.le = delta[DELTA_W-1] || (delta == '0);
		flags.over = CMP_W'(mag) > CMP_W'(thr);
	end

endmodule
`default_nettype wire

// ----- hw/rtl/wegc_merge.sv -----
`default_nettype none
module wegc_merge
	import wegc_pkg::*;
(
	input  logic [CNT_W-1:0]          smp   [WHEELS],
	input  logic signed [DELTA_W-1:0] delta [WHEELS],
	input  lane_flags_t               flags [WHEELS],
	input  logic [THR_W-1:0]          thr,
	input  logic [RUN_W-1:0]          limit,
	input  logic [RUN_W-1:0]          run,
	output logic signed [DELTA_W-1:0] mean,
	output decision_t                 dec,
	output logic [RUN_W-1:0]          run_next
);

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] adj;
	logic signed [SUM_W-1:0] quarter;
	logic                    read_fail;
	logic                    all_ge;
	logic                    all_le;
	logic                    any_over;
	logic                    mixed;
	logic                    mean_high;
	logic [1:0]              status;
	logic                    rollback;

	always_comb begin
		sum = SUM_W'(delta[0]) + SUM_W'(delta[1]) + SUM_W'(delta[2]) + SUM_W'(delta[3]);
		// round toward zero before the arithmetic shift
		adj = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
		quarter = adj >>> 2;
		mean = quarter[DELTA_W-1:0];

		read_fail = (&smp[1]) && (&smp[2]) && (&smp[3]);
		all_ge = flags[0].ge && flags[1].ge && flags[2].ge && flags[3].ge;
		all_le = flags[0].le && flags[1].le && flags[2].le && flags[3].le;
		any_over = flags[0].over || flags[1].over || flags[2].over || flags[3].over;
		mixed = (flags[0].le && flags[1].ge && flags[2].ge && flags[3].le) ||
			(flags[0].ge && flags[1].le && flags[2].le && flags[3].ge) ||
			(flags[0].ge && flags[1].ge && flags[2].le && flags[3].le) ||
			(flags[0].le && flags[1].le && flags[2].ge && flags[3].ge);
		mean_high = !mean[DELTA_W-1] && (CMP_W'(unsigned'(mean)) > CMP_W'(thr >> 2));

		status = STATUS_OK;
		rollback = 1'b0;
		if (read_fail) begin
			status = STATUS_READ_FAIL;
		end else if (all_ge || all_le) begin
			if (any_over) begin
				status = STATUS_MISMATCH;
				rollback = 1'b1;
			end
		end else if (mixed) begin
			if (mean_high) begin
				status = STATUS_MISMATCH;
				rollback = 1'b1;
			end
		end else begin
			status = STATUS_MISMATCH;
		end

		dec.status = status;
		dec.rollback = rollback;
		dec.retry = 1'b0;
		dec.reset = 1'b0;
		run_next = run;
		case (status)
			STATUS_READ_FAIL: begin
				dec.reset = 1'b1;
				run_next = '0;
			end
			STATUS_MISMATCH: begin
				if (run < limit) begin
					dec.retry = 1'b1;
					run_next = run + RUN_W'(1);
				end else begin
					dec.reset = 1'b1;
					run_next = '0;
				end
			end
			default: begin
				run_next = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/wheel_encoder_glitch_checker_core.sv -----
// Each result is registered into the output buffer when its sample is taken.
// Throughput: one sample per cycle while the skid entry is empty; the four
//   wheel lanes and the merge stage are combinational, closing the history update for the next sample.
// A two-entry output buffer keeps sample intake going while a result waits.
// Reset clears history and mismatch run, sets threshold 100 and retry limit 5.
`default_nettype none
module wheel_encoder_glitch_checker_core
	import wegc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	wegc_sample_if.sink         sample,
	wegc_result_if.source       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [THR_W-1:0]       thr_q;
	logic [RUN_W-1:0]       limit_q;
	logic [RUN_W-1:0]       run_q;
	logic [CNT_W-1:0]       cur_q   [WHEELS];
	logic [CNT_W-1:0]       last_q  [WHEELS];

	logic [CNT_W-1:0]          smp       [WHEELS];
	logic signed [DELTA_W-1:0] delta     [WHEELS];
	lane_flags_t               flags     [WHEELS];
	logic signed [DELTA_W-1:0] mean;
	decision_t                 dec;
	logic [RUN_W-1:0]          run_next;
	logic [CNT_W-1:0]          cur_next   [WHEELS];
	logic [CNT_W-1:0]          last_next  [WHEELS];
	result_t                   res;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    take;
	logic    pop;
	logic    cfg_wr;

	// APB configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {{(32-RUN_W){1'b0}}, limit_q}
		: {{(32-THR_W){1'b0}}, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(100);
			limit_q <= RUN_W'(5);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ERROR_THRESHOLD) begin
				thr_q <= pwdata[THR_W-1:0];
			end else begin
				limit_q <= pwdata[RUN_W-1:0];
			end
		end
	end

	assign smp[0] = sample.count_front_left[CNT_W-1:0];
	assign smp[1] = sample.count_front_right[CNT_W-1:0];
	assign smp[2] = sample.count_back_left[CNT_W-1:0];
	assign smp[3] = sample.count_back_right[CNT_W-1:0];

	for (genvar w = 0; w < WHEELS; w++) begin : g_lane
		wegc_lane u_lane (
			.smp   (smp[w]),
			.cur   (cur_q[w]),
			.mean  (mean),
			.thr   (thr_q),
			.delta (delta[w]),
			.flags (flags[w])
		);
	end

	wegc_merge u_merge (
		.smp      (smp),
		.delta    (delta),
		.flags    (flags),
		.thr      (thr_q),
		.limit    (limit_q),
		.run      (run_q),
		.mean     (mean),
		.dec      (dec),
		.run_next (run_next)
	);

	// The oldest history entry is always overwritten by last before any
	// rollback can read it, so only current and last are held.
	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			if (dec.reset) begin
				cur_next[w] = '0;
				last_next[w] = '0;
			end else if (dec.rollback) begin
				// drop the sample, restore the previous history
				cur_next[w] = cur_q[w];
				last_next[w] = last_q[w];
			end else begin
				cur_next[w] = smp[w];
				last_next[w] = cur_q[w];
			end
			res.kept[w] = FIELD_W'($signed(cur_next[w]));
		end
		res.status = dec.status;
		res.retry = dec.retry;
		res.reset = dec.reset;
	end

	assign sample.ready = !skid_valid_q;
	assign take = sample.valid && !skid_valid_q;
	assign pop = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			for (int w = 0; w < WHEELS; w++) begin
				cur_q[w] <= '0;
				last_q[w] <= '0;
			end
		end else if (take) begin
			run_q <= run_next;
			for (int w = 0; w < WHEELS; w++) begin
				cur_q[w] <= cur_next[w];
				last_q[w] <= last_next[w];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= take;
				end
			end else if (take) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= res;
			end
		end else if (take) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.check_status = out_q.status;
	assign result.retry_wanted = out_q.retry;
	assign result.reset_request = out_q.reset;
	assign result.kept_front_left = out_q.kept[0];
	assign result.kept_front_right = out_q.kept[1];
	assign result.kept_back_left = out_q.kept[2];
	assign result.kept_back_right = out_q.kept[3];

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dec.reset) |=> (run_q == '0 && cur_q[0] == '0 && last_q[3] == '0))
		else $error("history not cleared after reset request");

	a_ok_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dec.status == STATUS_OK) |=> (run_q == '0))
		else $error("mismatch run not cleared on consistent sample");

	a_retry_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.retry_wanted && result.reset_request))
		else $error("retry and reset request raised together");

endmodule
`default_nettype wire
